// ===== rtl/slipcrc_pkg.sv =====
// Constants, result codes and the byte-wide CRC-32 update for the SLIP CRC-32 frame decoder.
package slipcrc_pkg;

    // SLIP special characters.
    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    // CRC-32, reflected IEEE polynomial.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Fewest stored bytes that a frame with a CRC can hold.
    localparam logic [7:0] MIN_FRAME = 8'd5;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BADCRC  = 3'd2,
        KIND_SHORT   = 3'd3,
        KIND_OVERRUN = 3'd4
    } t_kind;

    // Payload of one result item.
    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [6:0] byte_index;
        logic [7:0] data_byte;
    } t_result;

    // Feeds one byte into the running CRC, lowest bit first.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] v);
        logic [31:0] c;
        c = crc_in ^ {24'd0, v};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/slip_crc32_frame_decoder_core.sv =====
// Top level of the SLIP deframer with CRC-32 frame check.
//
//  Channel   Dir  tdata (low bit up)                                    tuser
//  s_axis    in   wire_byte[7:0]                                        -
//  m_axis    out  data_byte[7:0], byte_index[14:8], frame_length[22:15], result_kind[2:0]
//                 frame_type[30:23], zero[31]
//
// A byte passes from the input register to the result register. The deframing,
// the CRC update and the verdict are all done combinationally between those
// two registers, so one byte is accepted in every cycle while the output side
// keeps taking. Reset is synchronous and active low; it clears the frame state
// and empties both registers. A stall on the output holds both stages and drops
// input ready only once the input register is also full.
module slip_crc32_frame_decoder_core #(
    parameter int MAX_FRAME = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // wire_byte[7:0]
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // data_byte[7:0], byte_index[14:8],
                                          // frame_length[22:15], frame_type[30:23]
    output logic [2:0]  o_m_axis_tuser    // result_kind[2:0]
);

    localparam logic [7:0] MaxCount = 8'(MAX_FRAME);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame state.
    logic        r_escape_pending, n_escape_pending;
    logic [7:0]  r_stored_count,   n_stored_count;
    logic        r_overrun_flag,   n_overrun_flag;
    logic [31:0] r_running_crc,    n_running_crc;
    logic [7:0]  r_tail [4];
    logic [7:0]  n_tail [4];
    logic [7:0]  r_first_byte,     n_first_byte;

    // Result register.
    logic                     r_out_valid;
    slipcrc_pkg::t_kind       r_out_kind;
    slipcrc_pkg::t_result     r_out_data;

    // Combinational result of the byte in the input register.
    logic                     emit;
    slipcrc_pkg::t_kind       res_kind;
    slipcrc_pkg::t_result     res_data;

    logic advance;   // the result register can take a new value this cycle
    logic work;      // the byte in the input register is processed this cycle

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign work            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        logic [7:0]  b;
        logic [31:0] want;
        logic        store;

        b     = r_in_byte;
        want  = {r_tail[3], r_tail[2], r_tail[1], r_tail[0]};
        store = 1'b0;

        n_escape_pending = r_escape_pending;
        n_stored_count   = r_stored_count;
        n_overrun_flag   = r_overrun_flag;
        n_running_crc    = r_running_crc;
        n_tail           = r_tail;
        n_first_byte     = r_first_byte;

        emit     = 1'b0;
        res_kind = slipcrc_pkg::KIND_DATA;
        res_data = '0;

        if (b == slipcrc_pkg::CODE_END) begin
            // END closes the frame; an empty frame gives no verdict.
            if (r_stored_count != 8'd0 || r_overrun_flag) begin
                emit = 1'b1;
                priority if (r_overrun_flag) begin
                    res_kind = slipcrc_pkg::KIND_OVERRUN;
                end else if (r_stored_count < slipcrc_pkg::MIN_FRAME) begin
                    res_kind = slipcrc_pkg::KIND_SHORT;
                end else if (~r_running_crc == want) begin
                    res_kind = slipcrc_pkg::KIND_GOOD;
                end else begin
                    res_kind = slipcrc_pkg::KIND_BADCRC;
                end
                res_data.frame_length = r_stored_count;
                res_data.frame_type   = r_first_byte;
            end
            n_escape_pending = 1'b0;
            n_stored_count   = 8'd0;
            n_overrun_flag   = 1'b0;
            n_running_crc    = slipcrc_pkg::CRC_INIT;
            n_tail           = '{default: 8'd0};
            n_first_byte     = 8'd0;
        end else if (r_escape_pending) begin
            // Escaped byte: only the two escape codes are translated.
            if (b == slipcrc_pkg::CODE_ESC_END) begin
                b = slipcrc_pkg::CODE_END;
            end else if (b == slipcrc_pkg::CODE_ESC_ESC) begin
                b = slipcrc_pkg::CODE_ESC;
            end
            n_escape_pending = 1'b0;
            store            = 1'b1;
        end else if (b == slipcrc_pkg::CODE_ESC) begin
            n_escape_pending = 1'b1;
        end else begin
            store = 1'b1;
        end

        if (store && !r_overrun_flag) begin
            if (r_stored_count >= MaxCount) begin
                // Frame full: discard everything up to the next END.
                n_overrun_flag = 1'b1;
            end else begin
                if (r_stored_count == 8'd0) begin
                    n_first_byte = b;
                end
                // The byte that leaves the delay line is no longer a CRC byte.
                if (r_stored_count >= 8'd4) begin
                    n_running_crc = slipcrc_pkg::crc_feed(r_running_crc, r_tail[0]);
                end
                n_tail[0] = r_tail[1];
                n_tail[1] = r_tail[2];
                n_tail[2] = r_tail[3];
                n_tail[3] = b;
                n_stored_count = r_stored_count + 8'd1;

                emit                = 1'b1;
                res_kind            = slipcrc_pkg::KIND_DATA;
                res_data.data_byte  = b;
                res_data.byte_index = r_stored_count[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_escape_pending <= 1'b0;
            r_stored_count   <= 8'd0;
            r_overrun_flag   <= 1'b0;
            r_running_crc    <= slipcrc_pkg::CRC_INIT;
            r_tail           <= '{default: 8'd0};
            r_first_byte     <= 8'd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= work && emit;
            end
            if (work) begin
                r_escape_pending <= n_escape_pending;
                r_stored_count   <= n_stored_count;
                r_overrun_flag   <= n_overrun_flag;
                r_running_crc    <= n_running_crc;
                r_tail           <= n_tail;
                r_first_byte     <= n_first_byte;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (work && emit) begin
            r_out_kind <= res_kind;
            r_out_data <= res_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};
    assign o_m_axis_tuser  = r_out_kind;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the SLIP CRC-32 frame decoder, which drives framed byte streams and checks the results.
module tb;

    localparam int FRAME_MAX    = 128;
    localparam int ITEM_GOAL    = 650;
    localparam int GAP_MAX      = 18;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int CYCLE_LIMIT  = 400000;

    // One decoder result as the checker expects it.
    typedef struct {
        slipcrc_pkg::t_kind kind;
        logic [7:0]         data_byte;
        logic [6:0]         byte_index;
        logic [7:0]         frame_length;
        logic [7:0]         frame_type;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Raw link bytes waiting to be sent, and decoder results still due.
    logic [7:0]  wire_q[$];
    t_expect     expected_q[$];
    t_expect     head;

    // Handshakes seen at the last rising edge, read by the drivers at the falling edge.
    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;

    int          fail_count  = 0;
    int unsigned cycle_count = 0;
    int          send_gap    = 0;
    int          send_burst  = 0;
    int          recv_wait   = 0;
    int          recv_burst  = 0;
    logic        next_valid;
    logic [7:0]  next_data;

    // Deframer state mirrored by the predictor.
    logic        esc_pending;
    int unsigned stored_bytes;
    logic        frame_overrun;
    logic [31:0] crc_acc;
    logic [7:0]  tail_bytes[4];  // [0] oldest, [3] newest
    logic [7:0]  frame_first;

    slip_crc32_frame_decoder_core #(
        .MAX_FRAME(FRAME_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Reflected CRC-32, one message bit at a time starting from bit 0.
    function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] v);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ v[i];
            r  = {1'b0, r[31:1]} ^ (fb ? slipcrc_pkg::CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    // Wait before the next item: mostly uniform, with stretches of back-to-back items.
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Payload bytes lean toward the SLIP special characters.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return slipcrc_pkg::CODE_END;
            1: return slipcrc_pkg::CODE_ESC;
            2: return $urandom_range(0, 1) ? slipcrc_pkg::CODE_ESC_END
                                           : slipcrc_pkg::CODE_ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic restart_frame();
        esc_pending   = 1'b0;
        stored_bytes  = 0;
        frame_overrun = 1'b0;
        crc_acc       = slipcrc_pkg::CRC_INIT;
        tail_bytes    = '{default: 8'd0};
        frame_first   = 8'd0;
    endtask

    // Works out what one accepted link byte makes the decoder emit.
    task automatic predict_wire_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic       keep;
        t_expect    e;
        b = raw;
        e.data_byte    = 8'd0;
        e.byte_index   = 7'd0;
        e.frame_length = 8'd0;
        e.frame_type   = 8'd0;
        if (b == slipcrc_pkg::CODE_END) begin
            // A frame end only reports when something was stored or the frame overflowed.
            if (stored_bytes != 0 || frame_overrun) begin
                if (frame_overrun)
                    e.kind = slipcrc_pkg::KIND_OVERRUN;
                else if (stored_bytes < slipcrc_pkg::MIN_FRAME)
                    e.kind = slipcrc_pkg::KIND_SHORT;
                else if (~crc_acc == {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]})
                    e.kind = slipcrc_pkg::KIND_GOOD;
                else
                    e.kind = slipcrc_pkg::KIND_BADCRC;
                e.frame_length = stored_bytes[7:0];
                e.frame_type   = frame_first;
                expected_q.push_back(e);
            end
            restart_frame();
        end else begin
            keep = 1'b1;
            if (esc_pending) begin
                if (b == slipcrc_pkg::CODE_ESC_END)
                    b = slipcrc_pkg::CODE_END;
                else if (b == slipcrc_pkg::CODE_ESC_ESC)
                    b = slipcrc_pkg::CODE_ESC;
                esc_pending = 1'b0;
            end else if (b == slipcrc_pkg::CODE_ESC) begin
                esc_pending = 1'b1;
                keep        = 1'b0;
            end
            if (keep && !frame_overrun) begin
                if (stored_bytes >= FRAME_MAX) begin
                    frame_overrun = 1'b1;
                end else begin
                    if (stored_bytes == 0)
                        frame_first = b;
                    // The byte leaving the four-byte tail is the one that enters the CRC.
                    if (stored_bytes >= 4)
                        crc_acc = crc32_byte(crc_acc, tail_bytes[0]);
                    tail_bytes[0] = tail_bytes[1];
                    tail_bytes[1] = tail_bytes[2];
                    tail_bytes[2] = tail_bytes[3];
                    tail_bytes[3] = b;
                    e.kind       = slipcrc_pkg::KIND_DATA;
                    e.data_byte  = b;
                    e.byte_index = stored_bytes[6:0];
                    expected_q.push_back(e);
                    stored_bytes++;
                end
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // SLIP-encodes one byte; now and then an ordinary byte is escaped as well.
    task automatic put_slip(input logic [7:0] b);
        if (b == slipcrc_pkg::CODE_END) begin
            wire_q.push_back(slipcrc_pkg::CODE_ESC);
            wire_q.push_back(slipcrc_pkg::CODE_ESC_END);
        end else if (b == slipcrc_pkg::CODE_ESC) begin
            wire_q.push_back(slipcrc_pkg::CODE_ESC);
            wire_q.push_back(slipcrc_pkg::CODE_ESC_ESC);
        end else begin
            if ($urandom_range(0, 15) == 0)
                wire_q.push_back(slipcrc_pkg::CODE_ESC);
            wire_q.push_back(b);
        end
    endtask

    // Queues a frame with its CRC appended little-endian; spoil flips one CRC bit.
    task automatic put_frame(input logic [7:0] body[$], input bit spoil);
        logic [31:0] acc;
        logic [31:0] fcs;
        acc = slipcrc_pkg::CRC_INIT;
        foreach (body[i])
            acc = crc32_byte(acc, body[i]);
        fcs = ~acc;
        if (spoil)
            fcs = fcs ^ (32'd1 << $urandom_range(0, 31));
        foreach (body[i])
            put_slip(body[i]);
        for (int k = 0; k < 4; k++)
            put_slip(fcs[8*k +: 8]);
        wire_q.push_back(slipcrc_pkg::CODE_END);
    endtask

    // Link byte driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
        end else begin
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (s_tvalid && in_taken)
                next_valid = 1'b0;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (wire_q.size() > 0) begin
                    next_data  = wire_q.pop_front();
                    next_valid = 1'b1;
                    send_gap   = draw_wait(send_burst);
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // Result side backpressure: a fresh stall is drawn after every accepted result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (out_taken)
                recv_wait = draw_wait(recv_burst);
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: checks each result against the oldest expectation, then predicts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            restart_frame();
        end else begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    note_failure($sformatf("unexpected result kind %0d tdata %08h",
                                           m_tuser, m_tdata));
                end else begin
                    head = expected_q.pop_front();
                    if (m_tuser !== head.kind || m_tdata[7:0] !== head.data_byte
                            || m_tdata[14:8] !== head.byte_index
                            || m_tdata[22:15] !== head.frame_length
                            || m_tdata[30:23] !== head.frame_type || m_tdata[31] !== 1'b0)
                        note_failure($sformatf({"expected kind %0d data %02h index %0d ",
                            "length %0d type %02h, got kind %0d data %02h index %0d ",
                            "length %0d type %02h pad %0b"},
                            head.kind, head.data_byte, head.byte_index, head.frame_length,
                            head.frame_type, m_tuser, m_tdata[7:0], m_tdata[14:8],
                            m_tdata[22:15], m_tdata[30:23], m_tdata[31]));
                end
            end
            if (s_tvalid && s_tready)
                predict_wire_byte(s_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [7:0] body[$];
        int         pick;
        int         len;

        // Directed: empty frame, short frames with extreme bytes and every escape form,
        // escape cut off by a frame end, one good and one corrupted minimum frame.
        wire_q.push_back(slipcrc_pkg::CODE_END);
        wire_q = {wire_q, 8'h00, 8'hFF, slipcrc_pkg::CODE_END};
        wire_q = {wire_q, slipcrc_pkg::CODE_ESC, slipcrc_pkg::CODE_ESC_END,
                  slipcrc_pkg::CODE_ESC, slipcrc_pkg::CODE_ESC_ESC,
                  slipcrc_pkg::CODE_ESC, 8'h41, slipcrc_pkg::CODE_END};
        wire_q = {wire_q, 8'h01, slipcrc_pkg::CODE_ESC, slipcrc_pkg::CODE_END};
        body = {8'h5A};
        put_frame(body, 1'b0);
        body = {8'hFF};
        put_frame(body, 1'b1);

        // Largest frame that fits, which also reaches the top byte index, then one two bytes longer.
        body.delete();
        repeat (FRAME_MAX - 4)
            body.push_back(pick_byte());
        put_frame(body, 1'b0);
        body.push_back(pick_byte());
        body.push_back(pick_byte());
        put_frame(body, 1'b0);

        // Random traffic: mostly well-formed frames with random content, plus corrupted
        // and short frames, frames near or over the size limit, and raw noise.
        while (wire_q.size() < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            body.delete();
            if ($urandom_range(0, 1) == 0)
                wire_q.push_back(slipcrc_pkg::CODE_END);
            if (pick < 70) begin
                len = $urandom_range(1, 20);
                repeat (len)
                    body.push_back(pick_byte());
                put_frame(body, pick >= 55);
            end else if (pick < 82) begin
                len = $urandom_range(0, 4);
                repeat (len)
                    put_slip(pick_byte());
                wire_q.push_back(slipcrc_pkg::CODE_END);
            end else if (pick < 85) begin
                len = $urandom_range(FRAME_MAX - 7, FRAME_MAX + 2);
                repeat (len)
                    body.push_back(pick_byte());
                put_frame(body, 1'b0);
            end else begin
                len = $urandom_range(1, 8);
                repeat (len)
                    wire_q.push_back(pick_byte());
            end
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (wire_q.size() != 0 || s_tvalid)
            @(negedge i_clk);
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== slip_crc32_frame_decoder_core.f =====
rtl/slipcrc_pkg.sv
rtl/slip_crc32_frame_decoder_core.sv
dv/tb.sv
